@@ hw/rtl/itp_pkg.sv @@
// Shared types and constants of the indented tree text parser.
// Holds the input and result word formats and the configuration port format.
// Used by every module of the parser.
package itp_pkg;

	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_BLANK = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;

	localparam logic [1:0] EV_NODE   = 2'd0;
	localparam logic [1:0] EV_ERROR  = 2'd1;
	localparam logic [1:0] EV_FINISH = 2'd2;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_BAD_NAME  = 2'd1;
	localparam logic [1:0] ST_BAD_DEPTH = 2'd2;
	localparam logic [1:0] ST_TOKEN_LEN = 2'd3;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;
	localparam logic [CFG_IDX_W-1:0] REG_TRIM_MODE     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STOP_ON_ERROR = 2'd1;

	typedef struct packed {
		logic [7:0] char_byte;
		logic       end_of_text;
	} in_word_t;

	// Input word with the classification done by the front part.
	typedef struct packed {
		logic [7:0] char_byte;
		logic       end_of_text;
		logic       is_lf;
		logic       is_nl;
	} cls_word_t;

	typedef struct packed {
		logic [1:0]  event_kind;
		logic [1:0]  status_code;
		logic [7:0]  indent_depth;
		logic [31:0] name_start;
		logic [31:0] name_stop;
		logic        has_value;
		logic [31:0] value_start;
		logic [31:0] value_stop;
		logic [31:0] line_number;
		logic        last_result;
	} out_word_t;

	typedef struct packed {
		logic [3:0] trim_mode;
		logic       stop_on_error;
	} cfg_t;

endpackage

@@ hw/rtl/itp_front.sv @@
// Front part of the parser: a two-word input queue that classifies bytes.
// Depends on itp_pkg for the word formats.
module itp_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  itp_pkg::in_word_t item,
	output logic              head_valid,
	output itp_pkg::cls_word_t head,
	input  logic              head_pop
);

	itp_pkg::cls_word_t mem_q [2];
	logic               wp_q;
	logic               rp_q;
	logic [1:0]         cnt_q;
	itp_pkg::cls_word_t cls;
	logic               do_push;
	logic               do_pop;

	always_comb begin
		cls.char_byte   = item.char_byte;
		cls.end_of_text = item.end_of_text;
		cls.is_lf       = (item.char_byte == itp_pkg::CH_LF);
		cls.is_nl       = (item.char_byte == itp_pkg::CH_LF) || (item.char_byte == itp_pkg::CH_CR);
	end

	assign full       = (cnt_q == 2'd2);
	assign head_valid = (cnt_q != 2'd0);
	assign head       = mem_q[rp_q];
	assign do_push    = push && !full;
	assign do_pop     = head_pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wp_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) begin
				wp_q <= ~wp_q;
			end
			if (do_pop) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

endmodule

@@ hw/rtl/itp_outq.sv @@
// Result queue of the parser: takes up to two words a cycle while it has room, gives one.
// Depends on itp_pkg for the result word format.
module itp_outq (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr0,
	input  logic               wr1,
	input  itp_pkg::out_word_t wd0,
	input  itp_pkg::out_word_t wd1,
	output logic               room,
	output logic               empty,
	input  logic               pop,
	output itp_pkg::out_word_t result
);

	itp_pkg::out_word_t mem_q [4];
	logic [1:0]         wp_q;
	logic [1:0]         rp_q;
	logic [2:0]         cnt_q;
	logic               do_pop;
	logic [2:0]         n_wr;

	assign room   = (cnt_q <= 3'd2);
	assign empty  = (cnt_q == 3'd0);
	assign result = mem_q[rp_q];
	assign do_pop = pop && !empty;
	assign n_wr   = {2'b0, wr0} + {2'b0, wr1};

	always_ff @(posedge clk) begin
		if (wr0) begin
			mem_q[wp_q] <= wd0;
		end
		if (wr1) begin
			mem_q[wp_q + 2'd1] <= wd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 2'd0;
			rp_q  <= 2'd0;
			cnt_q <= 3'd0;
		end else begin
			wp_q  <= wp_q + n_wr[1:0];
			if (do_pop) begin
				rp_q <= rp_q + 2'd1;
			end
			cnt_q <= cnt_q + n_wr - {2'b0, do_pop};
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 3'd4) else $error("result queue overflow");
	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		wr1 |-> wr0) else $error("second result written without first");
	a_room_on_write: assert property (@(posedge clk) disable iff (!arst_n)
		wr0 |-> room) else $error("result written without room");

endmodule

@@ hw/rtl/itp_back.sv @@
// Back part of the parser: line state machine, indent matching and replay.
// Depends on itp_pkg; feeds the result queue with complete per-item result sets.
module itp_back #(
	parameter int MAX_TOKEN_BYTES = 16,
	parameter int MAX_DEPTH       = 255,
	parameter int OFFSET_BITS     = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  itp_pkg::cfg_t      cfg,
	input  logic               in_valid,
	input  itp_pkg::cls_word_t in_word,
	output logic               in_pop,
	input  logic               out_room,
	output logic               wr0,
	output logic               wr1,
	output itp_pkg::out_word_t wd0,
	output itp_pkg::out_word_t wd1
);

	localparam int TLW = $clog2(MAX_TOKEN_BYTES + 1);
	localparam int TIW = (MAX_TOKEN_BYTES > 1) ? $clog2(MAX_TOKEN_BYTES) : 1;
	localparam int DW  = $clog2(MAX_DEPTH + 1);
	localparam int OB  = OFFSET_BITS;
	localparam logic [TLW-1:0] TOK_MAX = TLW'(MAX_TOKEN_BYTES);
	localparam logic [DW-1:0]  DEP_MAX = DW'(MAX_DEPTH);

	typedef enum logic [2:0] {
		PH_FIRST, PH_TOKEN, PH_INDENT, PH_LINE, PH_NAME, PH_LEAD, PH_VALUE, PH_SKIP
	} phase_t;

	typedef struct packed {
		logic               vld;
		itp_pkg::out_word_t w;
	} pend_t;

	function automatic logic [31:0] to32(input logic [OB-1:0] x);
		logic [OB+31:0] t;
		t = {32'b0, x};
		return t[31:0];
	endfunction

	logic [7:0]    tok_q [MAX_TOKEN_BYTES];
	logic [TLW-1:0] tok_len_q;
	logic [OB-1:0]  pos_q;
	logic [31:0]    line_q;
	logic [DW:0]    prev1_q;
	phase_t         phase_q;
	logic [TIW-1:0] match_q;
	logic [DW-1:0]  depth_q;
	logic [OB-1:0]  hns_q, hne_q, hvs_q, lkp_q;
	logic           cr_q;
	logic           halted_q;
	logic           rp_q;
	logic [TIW-1:0] rp_idx_q;
	logic [TIW-1:0] rp_len_q;
	pend_t          pend_q;

	logic [TLW-1:0] tok_len_n;
	logic [OB-1:0]  pos_n;
	logic [31:0]    line_n;
	logic [DW:0]    prev1_n;
	phase_t         phase_n;
	logic [TIW-1:0] match_n;
	logic [DW-1:0]  depth_n;
	logic [OB-1:0]  hns_n, hne_n, hvs_n, lkp_n;
	logic           cr_n, halted_n, rp_n;
	logic [TIW-1:0] rp_idx_n, rp_len_n;
	pend_t          pend_n;
	logic           tok_we;
	logic [TIW-1:0] tok_wa;
	logic [7:0]     tok_wd;

	logic [TIW-1:0] rd_idx;
	logic [7:0]     tok_rd;
	logic           go;
	logic           match_ok;
	logic [TLW-1:0] match_inc;
	logic           cb_en;
	phase_t         cb_ph;
	logic [7:0]     cb_c;
	logic [OB-1:0]  cb_p;
	logic           c_nl, c_blank, c_tab, c_lt, c_rt;
	phase_t         nd_ph;
	logic [OB-1:0]  nd_p;
	itp_pkg::out_word_t node_w, err_w, fin_w;
	logic [DW+7:0]  depth_ext;
	logic           e0_v, e1_v;
	itp_pkg::out_word_t e0, e1, cb_err;
	logic           cb_err_v;

	assign rd_idx    = rp_q ? rp_idx_q : match_q;
	assign tok_rd    = tok_q[rd_idx];
	assign go        = in_valid && out_room && !rp_q;
	assign match_inc = TLW'(match_q) + TLW'(1);
	assign match_ok  = (TLW'(match_q) < tok_len_q) && (tok_rd == in_word.char_byte);

	// Selects which byte, if any, goes through the line content logic this cycle.
	always_comb begin
		cb_en = 1'b0;
		cb_ph = phase_q;
		cb_c  = in_word.char_byte;
		cb_p  = pos_q;
		if (rp_q) begin
			cb_en = 1'b1;
			cb_c  = tok_rd;
			cb_p  = pos_q - OB'(rp_len_q) + OB'(rp_idx_q);
		end else if (go && !in_word.end_of_text && !halted_q && !(cr_q && in_word.is_lf)) begin
			if (phase_q == PH_INDENT) begin
				if (!match_ok && match_q == '0) begin
					cb_en = 1'b1;
					cb_ph = PH_LINE;
				end
			end else if (phase_q != PH_FIRST && phase_q != PH_TOKEN) begin
				cb_en = 1'b1;
			end
		end
	end

	assign c_nl    = (cb_c == itp_pkg::CH_LF) || (cb_c == itp_pkg::CH_CR);
	assign c_blank = (cb_c == itp_pkg::CH_BLANK);
	assign c_tab   = (cb_c == itp_pkg::CH_TAB);
	assign c_lt    = (c_blank && cfg.trim_mode[0]) || (c_tab && cfg.trim_mode[2]);
	assign c_rt    = (c_blank && cfg.trim_mode[1]) || (c_tab && cfg.trim_mode[3]);

	assign nd_ph     = cb_en ? cb_ph : phase_q;
	assign nd_p      = cb_en ? cb_p : pos_q;
	assign depth_ext = {8'b0, depth_q};

	always_comb begin
		node_w              = '0;
		node_w.event_kind   = itp_pkg::EV_NODE;
		node_w.status_code  = itp_pkg::ST_OK;
		node_w.indent_depth = (depth_ext > (DW+8)'(255)) ? 8'hFF : depth_ext[7:0];
		node_w.name_start   = to32(hns_q);
		node_w.name_stop    = (nd_ph == PH_NAME) ? to32(nd_p) : to32(hne_q);
		node_w.line_number  = line_q;
		if (nd_ph == PH_VALUE && lkp_q != hvs_q) begin
			node_w.has_value   = 1'b1;
			node_w.value_start = to32(hvs_q);
			node_w.value_stop  = to32(lkp_q);
		end
		err_w             = '0;
		err_w.event_kind  = itp_pkg::EV_ERROR;
		err_w.line_number = line_q;
		fin_w             = '0;
		fin_w.event_kind  = itp_pkg::EV_FINISH;
	end

	always_comb begin
		tok_len_n = tok_len_q;
		pos_n     = pos_q;
		line_n    = line_q;
		prev1_n   = prev1_q;
		phase_n   = phase_q;
		match_n   = match_q;
		depth_n   = depth_q;
		hns_n     = hns_q;
		hne_n     = hne_q;
		hvs_n     = hvs_q;
		lkp_n     = lkp_q;
		cr_n      = cr_q;
		halted_n  = halted_q;
		rp_n      = rp_q;
		rp_idx_n  = rp_idx_q;
		rp_len_n  = rp_len_q;
		pend_n    = pend_q;
		tok_we    = 1'b0;
		tok_wa    = '0;
		tok_wd    = in_word.char_byte;
		in_pop    = 1'b0;
		e0_v      = 1'b0;
		e1_v      = 1'b0;
		e0        = node_w;
		e1        = fin_w;
		cb_err_v  = 1'b0;
		cb_err    = err_w;

		if (rp_q) begin
			rp_idx_n = rp_idx_q + TIW'(1);
			if ((TIW+1)'(rp_idx_q) + (TIW+1)'(1) == (TIW+1)'(rp_len_q)) begin
				rp_n = 1'b0;
			end
		end else if (go) begin
			in_pop = 1'b1;
			pos_n  = pos_q + OB'(1);
			if (in_word.end_of_text) begin
				pos_n = pos_q;
				if (!halted_q && phase_q == PH_INDENT && match_q != '0) begin
					// Take back the partial indent before closing the text.
					in_pop   = 1'b0;
					rp_n     = 1'b1;
					rp_idx_n = '0;
					rp_len_n = match_q;
					phase_n  = PH_LINE;
					match_n  = '0;
				end else begin
					if (!halted_q && (phase_q == PH_NAME || phase_q == PH_LEAD ||
						phase_q == PH_VALUE)) begin
						e0_v = 1'b1;
						e1_v = 1'b1;
					end else begin
						e0_v = 1'b1;
						e0   = fin_w;
					end
					tok_len_n = '0;
					pos_n     = '0;
					line_n    = 32'd2;
					prev1_n   = '0;
					phase_n   = PH_FIRST;
					match_n   = '0;
					depth_n   = '0;
					hns_n     = '0;
					hne_n     = '0;
					hvs_n     = '0;
					lkp_n     = '0;
					cr_n      = 1'b0;
					halted_n  = 1'b0;
				end
			end else if (halted_q) begin
				cr_n = cr_q;
			end else if (cr_q && in_word.is_lf) begin
				cr_n = 1'b0;
			end else begin
				cr_n = 1'b0;
				unique case (phase_q)
					PH_FIRST: begin
						tok_we    = 1'b1;
						tok_len_n = TLW'(1);
						if (in_word.is_nl) begin
							tok_wd  = itp_pkg::CH_TAB;
							phase_n = PH_INDENT;
							line_n  = 32'd2;
							cr_n    = !in_word.is_lf;
						end else begin
							phase_n = PH_TOKEN;
						end
					end
					PH_TOKEN: begin
						if (in_word.is_nl) begin
							phase_n = PH_INDENT;
							line_n  = 32'd2;
							cr_n    = !in_word.is_lf;
						end else if (tok_len_q >= TOK_MAX) begin
							e0_v             = 1'b1;
							e0               = err_w;
							e0.status_code   = itp_pkg::ST_TOKEN_LEN;
							e0.line_number   = 32'd1;
							halted_n         = 1'b1;
						end else begin
							tok_we    = 1'b1;
							tok_wa    = tok_len_q[TIW-1:0];
							tok_len_n = tok_len_q + TLW'(1);
						end
					end
					PH_INDENT: begin
						if (match_ok) begin
							if (match_inc >= tok_len_q) begin
								match_n = '0;
								if (depth_q < DEP_MAX) begin
									depth_n = depth_q + DW'(1);
								end
							end else begin
								match_n = match_inc[TIW-1:0];
							end
						end else if (match_q != '0) begin
							// Replay the matched bytes first; the item stays queued.
							in_pop   = 1'b0;
							pos_n    = pos_q;
							rp_n     = 1'b1;
							rp_idx_n = '0;
							rp_len_n = match_q;
							phase_n  = PH_LINE;
							match_n  = '0;
						end
					end
					default: begin
					end
				endcase
			end
		end

		// Line content logic, shared by replayed and incoming bytes.
		if (cb_en) begin
			if (c_nl) begin
				if (cb_ph == PH_NAME || cb_ph == PH_LEAD || cb_ph == PH_VALUE) begin
					e0_v    = 1'b1;
					e0      = node_w;
					prev1_n = (DW+1)'(depth_q) + (DW+1)'(1);
				end
				line_n  = line_q + 32'd1;
				phase_n = PH_INDENT;
				match_n = '0;
				depth_n = '0;
				cr_n    = (cb_c == itp_pkg::CH_CR);
			end else begin
				unique case (cb_ph)
					PH_LINE: begin
						if (c_blank || c_tab) begin
							cb_err_v           = 1'b1;
							cb_err.status_code = itp_pkg::ST_BAD_NAME;
						end else if ((DW+1)'(depth_q) > prev1_q) begin
							cb_err_v           = 1'b1;
							cb_err.status_code = itp_pkg::ST_BAD_DEPTH;
						end else begin
							hns_n   = cb_p;
							phase_n = PH_NAME;
						end
					end
					PH_NAME: begin
						if (c_blank) begin
							hne_n   = cb_p;
							phase_n = PH_LEAD;
						end
					end
					PH_LEAD: begin
						if (!c_lt) begin
							hvs_n   = cb_p;
							lkp_n   = c_rt ? cb_p : cb_p + OB'(1);
							phase_n = PH_VALUE;
						end
					end
					PH_VALUE: begin
						if (!c_rt) begin
							lkp_n = cb_p + OB'(1);
						end
					end
					default: begin
					end
				endcase
				if (cb_err_v) begin
					if (cfg.stop_on_error) begin
						halted_n = 1'b1;
						if (rp_q) begin
							rp_n = 1'b0;
						end
					end else begin
						phase_n = PH_SKIP;
					end
					if (rp_q) begin
						pend_n.vld = 1'b1;
						pend_n.w   = cb_err;
					end else begin
						e0_v = 1'b1;
						e0   = cb_err;
					end
				end
			end
		end

		// All results of one item leave together, so the last one can be marked.
		wr0 = 1'b0;
		wr1 = 1'b0;
		wd0 = e0;
		wd1 = e1;
		if (in_pop) begin
			if (pend_q.vld) begin
				wd0    = pend_q.w;
				wd1    = e0;
				wr0    = 1'b1;
				wr1    = e0_v;
				pend_n = '0;
			end else begin
				wr0 = e0_v;
				wr1 = e1_v;
			end
			if (wr1) begin
				wd1.last_result = 1'b1;
			end else begin
				wd0.last_result = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tok_we) begin
			tok_q[tok_wa] <= tok_wd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_len_q <= '0;
			pos_q     <= '0;
			line_q    <= 32'd2;
			prev1_q   <= '0;
			phase_q   <= PH_FIRST;
			match_q   <= '0;
			depth_q   <= '0;
			hns_q     <= '0;
			hne_q     <= '0;
			hvs_q     <= '0;
			lkp_q     <= '0;
			cr_q      <= 1'b0;
			halted_q  <= 1'b0;
			rp_q      <= 1'b0;
			rp_idx_q  <= '0;
			rp_len_q  <= '0;
			pend_q    <= '0;
		end else begin
			tok_len_q <= tok_len_n;
			pos_q     <= pos_n;
			line_q    <= line_n;
			prev1_q   <= prev1_n;
			phase_q   <= phase_n;
			match_q   <= match_n;
			depth_q   <= depth_n;
			hns_q     <= hns_n;
			hne_q     <= hne_n;
			hvs_q     <= hvs_n;
			lkp_q     <= lkp_n;
			cr_q      <= cr_n;
			halted_q  <= halted_n;
			rp_q      <= rp_n;
			rp_idx_q  <= rp_idx_n;
			rp_len_q  <= rp_len_n;
			pend_q    <= pend_n;
		end
	end

	a_replay_holds_item: assert property (@(posedge clk) disable iff (!arst_n)
		rp_q |-> in_valid) else $error("replay without a queued item");
	a_no_replay_halted: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |-> !rp_q) else $error("replay while halted");
	a_pend_in_replay: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q.vld |-> (rp_q || in_valid)) else $error("held error without item");
	a_pop_not_in_replay: assert property (@(posedge clk) disable iff (!arst_n)
		rp_q |-> !in_pop) else $error("item popped during replay");

endmodule

@@ hw/rtl/indented_tree_text_parser_unit.sv @@
// Top level of the indented tree text parser.
// Instantiates itp_front, itp_back and itp_outq; uses itp_pkg types.
//
//   channel   | handshake          | word
//   ----------+--------------------+--------------------------------------
//   input     | push / full        | item   (char_byte, end_of_text)
//   result    | empty / pop        | result (node, error or finished event)
//   config    | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// The back part handles an item combinationally and pops it once the result
// queue has room. A partly matched indent token is replayed byte by byte
// from the single token store read port, while the breaking item stays queued.
// Reset clears all parse state; no clearing pass is needed.
// Input and result sides stall on their own through the two queues.
module indented_tree_text_parser_unit #(
	parameter int MAX_TOKEN_BYTES = 16,
	parameter int MAX_DEPTH       = 255,
	parameter int OFFSET_BITS     = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 push,
	output logic                                 full,
	input  itp_pkg::in_word_t                    item,
	output logic                                 empty,
	input  logic                                 pop,
	output itp_pkg::out_word_t                   result,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [itp_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [itp_pkg::CFG_DATA_W-1:0]       cfg_data
);

	itp_pkg::cfg_t      cfg_q;
	logic               head_valid;
	itp_pkg::cls_word_t head;
	logic               head_pop;
	logic               room;
	logic               wr0, wr1;
	itp_pkg::out_word_t wd0, wd1;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.trim_mode     <= 4'd0;
			cfg_q.stop_on_error <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == itp_pkg::REG_TRIM_MODE) begin
				cfg_q.trim_mode <= cfg_data[3:0];
			end else if (cfg_index == itp_pkg::REG_STOP_ON_ERROR) begin
				cfg_q.stop_on_error <= cfg_data[0];
			end
		end
	end

	itp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.item       (item),
		.head_valid (head_valid),
		.head       (head),
		.head_pop   (head_pop)
	);

	itp_back #(
		.MAX_TOKEN_BYTES (MAX_TOKEN_BYTES),
		.MAX_DEPTH       (MAX_DEPTH),
		.OFFSET_BITS     (OFFSET_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (head_valid),
		.in_word  (head),
		.in_pop   (head_pop),
		.out_room (room),
		.wr0      (wr0),
		.wr1      (wr1),
		.wd0      (wd0),
		.wd1      (wd1)
	);

	itp_outq u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr0    (wr0),
		.wr1    (wr1),
		.wd0    (wd0),
		.wd1    (wd1),
		.room   (room),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

endmodule

@@ tb/tb_indented_tree_text_parser_unit.sv @@
// Self-checking testbench of the indented tree text parser unit.
// Streams directed and random texts, predicts every event word and checks it.
// Depends on itp_pkg and indented_tree_text_parser_unit.
module tb_indented_tree_text_parser_unit;

	typedef enum int {PS_FIRST, PS_TOKEN, PS_INDENT, PS_LINE, PS_NAME, PS_LEAD, PS_VALUE,
		PS_SKIP} parse_state_t;

	// Register indexes that the block does not implement.
	localparam logic [itp_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [itp_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	itp_pkg::in_word_t item = '0;
	logic empty;
	logic pop = 1'b0;
	itp_pkg::out_word_t result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [itp_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [itp_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	indented_tree_text_parser_unit dut (.*);

	always #5 clk = ~clk;

	// Words waiting to be pushed and events still to come out.
	itp_pkg::in_word_t text_words[$];
	itp_pkg::out_word_t event_q[$];
	itp_pkg::out_word_t step_events[$];
	int send_idle_pct = 0;
	int pop_stall_pct = 0;
	int fail_count = 0;
	int words_sent = 0;
	int events_seen = 0;
	int texts_made = 0;

	// Mirror of the parser state and its registers.
	logic [3:0] trim_cfg;
	logic halt_cfg;
	logic [7:0] tok_bytes[16];
	int tok_len;
	logic [31:0] pos;
	logic [31:0] line_no;
	int prev_depth;
	parse_state_t ps;
	int match_cnt;
	int depth_cnt;
	logic [31:0] name_lo, name_hi, val_lo, val_end;
	bit cr_pending;
	bit stopped;

	function automatic void restart_text();
		tok_len = 0;
		pos = '0;
		line_no = 32'd2;
		prev_depth = -1;
		ps = PS_FIRST;
		match_cnt = 0;
		depth_cnt = 0;
		name_lo = '0;
		name_hi = '0;
		val_lo = '0;
		val_end = '0;
		cr_pending = 0;
		stopped = 0;
	endfunction

	function automatic void add_event(logic [1:0] kind, logic [1:0] status, int depth,
			logic [31:0] ns, logic [31:0] ne, logic hv, logic [31:0] vs, logic [31:0] ve,
			logic [31:0] line);
		itp_pkg::out_word_t w;
		if (step_events.size() >= 2)
			return;
		w.event_kind = kind;
		w.status_code = status;
		w.indent_depth = (depth > 255) ? 8'd255 : depth[7:0];
		w.name_start = ns;
		w.name_stop = ne;
		w.has_value = hv;
		w.value_start = vs;
		w.value_stop = ve;
		w.line_number = line;
		w.last_result = 1'b0;
		step_events.push_back(w);
	endfunction

	function automatic void start_line();
		line_no++;
		ps = PS_INDENT;
		match_cnt = 0;
		depth_cnt = 0;
	endfunction

	function automatic void flag_error(logic [1:0] code);
		add_event(itp_pkg::EV_ERROR, code, 0, '0, '0, 1'b0, '0, '0, line_no);
		if (halt_cfg)
			stopped = 1;
		else
			ps = PS_SKIP;
	endfunction

	function automatic void close_node(logic [31:0] p);
		logic [31:0] ne;
		ne = (ps == PS_NAME) ? p : name_hi;
		if (ps == PS_VALUE && val_end != val_lo)
			add_event(itp_pkg::EV_NODE, itp_pkg::ST_OK, depth_cnt, name_lo, ne, 1'b1,
				val_lo, val_end, line_no);
		else
			add_event(itp_pkg::EV_NODE, itp_pkg::ST_OK, depth_cnt, name_lo, ne, 1'b0,
				'0, '0, line_no);
		prev_depth = depth_cnt;
	endfunction

	function automatic bit trims_left(logic [7:0] b);
		return (b == itp_pkg::CH_BLANK && trim_cfg[0]) || (b == itp_pkg::CH_TAB && trim_cfg[2]);
	endfunction

	function automatic bit trims_right(logic [7:0] b);
		return (b == itp_pkg::CH_BLANK && trim_cfg[1]) || (b == itp_pkg::CH_TAB && trim_cfg[3]);
	endfunction

	function automatic void line_byte(logic [7:0] b, logic [31:0] p);
		if (b == itp_pkg::CH_LF || b == itp_pkg::CH_CR) begin
			if (ps == PS_NAME || ps == PS_LEAD || ps == PS_VALUE)
				close_node(p);
			start_line();
			if (b == itp_pkg::CH_CR)
				cr_pending = 1;
			return;
		end
		case (ps)
			PS_LINE: begin
				if (b == itp_pkg::CH_BLANK || b == itp_pkg::CH_TAB)
					flag_error(itp_pkg::ST_BAD_NAME);
				else if (prev_depth + 1 < depth_cnt)
					flag_error(itp_pkg::ST_BAD_DEPTH);
				else begin
					name_lo = p;
					ps = PS_NAME;
				end
			end
			PS_NAME: begin
				if (b == itp_pkg::CH_BLANK) begin
					name_hi = p;
					ps = PS_LEAD;
				end
			end
			PS_LEAD: begin
				if (!trims_left(b)) begin
					val_lo = p;
					val_end = trims_right(b) ? p : p + 32'd1;
					ps = PS_VALUE;
				end
			end
			PS_VALUE: begin
				if (!trims_right(b))
					val_end = p + 32'd1;
			end
			default: ;
		endcase
	endfunction

	// A partly matched indent token is taken back as the start of the line.
	function automatic void replay_partial();
		int m;
		m = match_cnt;
		ps = PS_LINE;
		match_cnt = 0;
		for (int i = 0; i < m && !stopped; i++)
			line_byte(tok_bytes[i], pos - 32'(m) + 32'(i));
	endfunction

	function automatic void predict_word(itp_pkg::in_word_t w);
		logic [7:0] b;
		b = w.char_byte;
		step_events.delete();
		if (w.end_of_text) begin
			if (!stopped) begin
				if (ps == PS_INDENT && match_cnt > 0)
					replay_partial();
				if (!stopped && (ps == PS_NAME || ps == PS_LEAD || ps == PS_VALUE))
					close_node(pos);
			end
			add_event(itp_pkg::EV_FINISH, itp_pkg::ST_OK, 0, '0, '0, 1'b0, '0, '0, '0);
			restart_text();
		end else if (stopped) begin
			pos++;
		end else if (cr_pending && b == itp_pkg::CH_LF) begin
			cr_pending = 0;
			pos++;
		end else begin
			cr_pending = 0;
			case (ps)
				PS_FIRST: begin
					if (b == itp_pkg::CH_LF || b == itp_pkg::CH_CR) begin
						tok_bytes[0] = itp_pkg::CH_TAB;
						tok_len = 1;
						start_line();
						line_no = 32'd2;
						if (b == itp_pkg::CH_CR)
							cr_pending = 1;
					end else begin
						tok_bytes[0] = b;
						tok_len = 1;
						ps = PS_TOKEN;
					end
				end
				PS_TOKEN: begin
					if (b == itp_pkg::CH_LF || b == itp_pkg::CH_CR) begin
						start_line();
						line_no = 32'd2;
						if (b == itp_pkg::CH_CR)
							cr_pending = 1;
					end else if (tok_len >= 16) begin
						add_event(itp_pkg::EV_ERROR, itp_pkg::ST_TOKEN_LEN, 0, '0, '0, 1'b0,
							'0, '0, 32'd1);
						stopped = 1;
					end else begin
						tok_bytes[tok_len] = b;
						tok_len++;
					end
				end
				PS_INDENT: begin
					if (match_cnt < tok_len && tok_bytes[match_cnt] == b) begin
						match_cnt++;
						if (match_cnt >= tok_len) begin
							match_cnt = 0;
							if (depth_cnt < 255)
								depth_cnt++;
						end
					end else begin
						replay_partial();
						if (!stopped)
							line_byte(b, pos);
					end
				end
				default: line_byte(b, pos);
			endcase
			pos++;
		end
		if (step_events.size() > 0)
			step_events[step_events.size() - 1].last_result = 1'b1;
		foreach (step_events[i])
			event_q.push_back(step_events[i]);
	endfunction

	// Accepted words feed the predictor; the driver moves on at the falling edge.
	always @(posedge clk) begin
		if (push && !full) begin
			predict_word(item);
			void'(text_words.pop_front());
			words_sent++;
		end
	end

	always @(negedge clk) begin
		if (arst_n && text_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
			push <= 1'b1;
			item <= text_words[0];
		end else begin
			push <= 1'b0;
		end
		pop <= arst_n && ($urandom_range(99) >= pop_stall_pct);
	end

	function automatic void cmp_field(string fname, logic [31:0] e, logic [31:0] a);
		if (e !== a) begin
			$display("%0t: mismatch in %s: expected %0h, got %0h", $time, fname, e, a);
			fail_count++;
		end
	endfunction

	always @(posedge clk) begin
		itp_pkg::out_word_t e;
		if (pop && !empty) begin
			events_seen++;
			if (event_q.size() == 0) begin
				$display("%0t: unexpected event word, expected none, got %h", $time, result);
				fail_count++;
			end else begin
				e = event_q.pop_front();
				cmp_field("event_kind", 32'(e.event_kind), 32'(result.event_kind));
				cmp_field("status_code", 32'(e.status_code), 32'(result.status_code));
				cmp_field("indent_depth", 32'(e.indent_depth), 32'(result.indent_depth));
				cmp_field("name_start", e.name_start, result.name_start);
				cmp_field("name_stop", e.name_stop, result.name_stop);
				cmp_field("has_value", 32'(e.has_value), 32'(result.has_value));
				cmp_field("value_start", e.value_start, result.value_start);
				cmp_field("value_stop", e.value_stop, result.value_stop);
				cmp_field("line_number", e.line_number, result.line_number);
				cmp_field("last_result", 32'(e.last_result), 32'(result.last_result));
			end
		end
	end

	task automatic put_byte(logic [7:0] b);
		itp_pkg::in_word_t w;
		w.char_byte = b;
		w.end_of_text = 1'b0;
		text_words.push_back(w);
	endtask

	task automatic put_str(string s);
		for (int i = 0; i < s.len(); i++)
			put_byte(s[i]);
	endtask

	task automatic put_end();
		itp_pkg::in_word_t w;
		w.char_byte = 8'($urandom_range(255));
		w.end_of_text = 1'b1;
		text_words.push_back(w);
		texts_made++;
	endtask

	task automatic put_newline(int style);
		case (style)
			0: put_byte(itp_pkg::CH_LF);
			1: put_byte(itp_pkg::CH_CR);
			default: begin
				put_byte(itp_pkg::CH_CR);
				put_byte(itp_pkg::CH_LF);
			end
		endcase
	endtask

	function automatic logic [7:0] name_char();
		if ($urandom_range(9) == 0)
			return 8'($urandom_range(255));
		return 8'($urandom_range(33, 255));
	endfunction

	task automatic make_text();
		logic [7:0] tok[$];
		int style, nlines, depth, kind, n;
		style = $urandom_range(2);
		case ($urandom_range(9))
			0: ;
			1, 2, 3: tok.push_back(itp_pkg::CH_TAB);
			4, 5: repeat ($urandom_range(1, 2) * 2) tok.push_back(itp_pkg::CH_BLANK);
			6, 7: repeat ($urandom_range(1, 16)) tok.push_back(8'($urandom_range(33, 255)));
			default: begin
				n = ($urandom_range(1)) ? 16 : $urandom_range(17, 20);
				repeat (n) tok.push_back($urandom_range(1) ? itp_pkg::CH_BLANK :
					8'($urandom_range(33, 255)));
			end
		endcase
		foreach (tok[i])
			put_byte(tok[i]);
		put_newline(style);
		if (tok.size() == 0)
			tok.push_back(itp_pkg::CH_TAB);
		nlines = $urandom_range(1, 8);
		depth = 0;
		for (int l = 0; l < nlines; l++) begin
			if ($urandom_range(3) == 0)
				style = $urandom_range(2);
			kind = $urandom_range(19);
			if (kind == 0) begin
				put_newline(style);
				continue;
			end
			if (kind == 1) begin
				// Pure noise, newlines and token bytes included.
				repeat ($urandom_range(1, 12)) put_byte(8'($urandom_range(255)));
				put_newline(style);
				continue;
			end
			if (kind == 2)
				depth = depth + 2;
			else if ($urandom_range(2) == 0)
				depth = depth + 1;
			else
				depth = $urandom_range(depth);
			repeat (depth) foreach (tok[i]) put_byte(tok[i]);
			if (kind == 3 && tok.size() > 1) begin
				n = $urandom_range(1, tok.size() - 1);
				for (int i = 0; i < n; i++)
					put_byte(tok[i]);
			end
			if (kind == 4)
				put_byte($urandom_range(1) ? itp_pkg::CH_BLANK : itp_pkg::CH_TAB);
			if (kind != 5)
				repeat ($urandom_range(1, 6)) put_byte(name_char());
			if ($urandom_range(1)) begin
				put_byte(itp_pkg::CH_BLANK);
				repeat ($urandom_range(0, 8)) begin
					case ($urandom_range(2))
						0: put_byte(itp_pkg::CH_BLANK);
						1: put_byte(itp_pkg::CH_TAB);
						default: put_byte(name_char());
					endcase
				end
			end
			if (l < nlines - 1 || $urandom_range(1))
				put_newline(style);
		end
		put_end();
	endtask

	task automatic write_reg(logic [itp_pkg::CFG_IDX_W-1:0] idx,
			logic [itp_pkg::CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		if (idx == itp_pkg::REG_TRIM_MODE)
			trim_cfg = data[3:0];
		else if (idx == itp_pkg::REG_STOP_ON_ERROR)
			halt_cfg = data[0];
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic drain();
		while (text_words.size() > 0 || event_q.size() > 0)
			@(posedge clk);
		// Trailing words may still be in flight without any event.
		repeat (40) @(posedge clk);
	endtask

	initial begin
		int sends[4];
		int stalls[4];
		sends = '{0, 86, 0, 34};
		stalls = '{0, 0, 86, 34};
		trim_cfg = 4'd0;
		halt_cfg = 1'b1;
		restart_text();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed texts: empty, indentation only, partial token, empty line,
		// bad name, depth jump, over-long token and halting.
		put_end();
		put_byte(itp_pkg::CH_LF);
		put_byte(itp_pkg::CH_TAB);
		put_end();
		put_str("  \r\n");
		put_str("a b\n\n ");
		put_end();
		put_str("\t\r");
		put_str("\t\tz\n x");
		put_end();
		put_str("0123456789abcdefgh");
		put_end();
		drain();

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					write_reg(itp_pkg::REG_TRIM_MODE, 8'hF0);
					write_reg(itp_pkg::REG_STOP_ON_ERROR, 8'h00);
				end
				1: begin
					write_reg(itp_pkg::REG_TRIM_MODE, 8'h0F);
					write_reg(itp_pkg::REG_STOP_ON_ERROR, 8'hFE);
					write_reg(REG_SPARE_B, 8'($urandom_range(255)));
				end
				2: begin
					write_reg(itp_pkg::REG_TRIM_MODE, 8'($urandom_range(255)));
					write_reg(itp_pkg::REG_STOP_ON_ERROR, 8'h01);
				end
				default: begin
					write_reg(itp_pkg::REG_TRIM_MODE, 8'($urandom_range(255)));
					write_reg(itp_pkg::REG_STOP_ON_ERROR, 8'($urandom_range(255)));
					write_reg(REG_SPARE_A, 8'($urandom_range(255)));
				end
			endcase
			send_idle_pct = sends[ph];
			pop_stall_pct = stalls[ph];
			while (text_words.size() < 500)
				make_text();
			drain();
		end

		$display("Sent %0d words in %0d texts and checked %0d event words over four",
			words_sent, texts_made, events_seen);
		$display("idle and stall phases with several trim and halt settings.");
		if (fail_count == 0)
			$display("tb_indented_tree_text_parser_unit: PASS");
		else
			$display("tb_indented_tree_text_parser_unit: FAIL");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("tb_indented_tree_text_parser_unit: FAIL");
		$finish;
	end

endmodule

@@ indented_tree_text_parser_unit.f @@
hw/rtl/itp_pkg.sv
hw/rtl/itp_front.sv
hw/rtl/itp_outq.sv
hw/rtl/itp_back.sv
hw/rtl/indented_tree_text_parser_unit.sv
tb/tb_indented_tree_text_parser_unit.sv
